@@ rtl/q4bda_pkg.sv @@
// ----------------------------------------------------------------------------
// q4bda_pkg
// types, constants and helpers shared by the q4 block dot accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package q4bda_pkg;

   localparam int BLOCK_ELEMS = 32;
   localparam int LANE_GROUPS = 4;
   localparam int GROUP_ELEMS = BLOCK_ELEMS / LANE_GROUPS;
   localparam int PART_W      = 16;
   localparam int DOT_W       = 18;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int NIB_BIAS    = 8;
   localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;
   localparam logic [95:0] ROUND_HALF = 96'h8000;
   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   // register indexes of the csr port
   localparam logic CSR_FORMAT_MODE = 1'b0;
   localparam logic CSR_ACT_SCALE   = 1'b1;

   typedef enum logic [1:0] {
      CLS_FIN  = 2'd0,
      CLS_PINF = 2'd1,
      CLS_NINF = 2'd2,
      CLS_NAN  = 2'd3
   } cls_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TERM,
      S_ACC,
      S_MUL_LO,
      S_MUL_HI,
      S_ROUND
   } state_type;

   // decoded fp16 operand
   typedef struct packed {
      logic        neg;
      logic        special;
      logic        nan_f;
      logic [10:0] mant;
      logic [4:0]  shift;
   } half_type;

   typedef struct packed {
      logic signed [LANE_GROUPS-1:0][PART_W-1:0] part;
      half_type           d;
      half_type           m;
      logic signed [12:0] act_sum;
      logic               last;
   } entry_type;

   function automatic half_type half_decode(input logic [15:0] h);
      half_type r;
      r.neg     = h[15];
      r.special = (h[14:10] == 5'h1F);
      r.nan_f   = (h[9:0] != 10'd0);
      r.mant    = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
      r.shift   = (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
      return r;
   endfunction

   function automatic cls_type half_cls(input half_type h, input logic k_zero,
                                        input logic k_neg);
      cls_type r;
      if (!h.special)
         r = CLS_FIN;
      else if (h.nan_f || k_zero)
         r = CLS_NAN;
      else if (h.neg != k_neg)
         r = CLS_NINF;
      else
         r = CLS_PINF;
      return r;
   endfunction

   function automatic cls_type merge_cls(input cls_type a, input cls_type b);
      cls_type r;
      if (a == CLS_FIN)
         r = b;
      else if (b == CLS_FIN)
         r = a;
      else if (a == b)
         r = a;
      else
         r = CLS_NAN;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/q4bda_front.sv @@
// ----------------------------------------------------------------------------
// q4bda_front
// lane multiplies, group sums and fp16 decode of one incoming block
// ----------------------------------------------------------------------------
`default_nettype none

module q4bda_front (
   input  wire logic        format_mode,
   input  wire logic [63:0] nibbles_low,
   input  wire logic [63:0] nibbles_high,
   input  wire logic [63:0] act_word_0,
   input  wire logic [63:0] act_word_1,
   input  wire logic [63:0] act_word_2,
   input  wire logic [63:0] act_word_3,
   input  wire logic [15:0] block_scale,
   input  wire logic [15:0] block_offset,
   input  wire logic signed [12:0] act_sum,
   input  wire logic        last_block,
   output q4bda_pkg::entry_type entry
);

   logic [255:0] acts;
   logic [127:0] nibs;
   logic signed [4:0]  bias;
   logic signed [q4bda_pkg::BLOCK_ELEMS-1:0][12:0] prod;

   assign acts = {act_word_3, act_word_2, act_word_1, act_word_0};
   assign nibs = {nibbles_high, nibbles_low};
   assign bias = format_mode ? 5'sd0 : 5'(q4bda_pkg::NIB_BIAS);

   // low nibble of byte j meets activation j, high nibble activation j+16
   always_comb begin
      for (int j = 0; j < q4bda_pkg::BLOCK_ELEMS / 2; j++) begin
         prod[j] = $signed(acts[8*j +: 8])
                 * ($signed({1'b0, nibs[8*j +: 4]}) - bias);
         prod[j + q4bda_pkg::BLOCK_ELEMS / 2] =
                   $signed(acts[8*(j + q4bda_pkg::BLOCK_ELEMS / 2) +: 8])
                 * ($signed({1'b0, nibs[8*j + 4 +: 4]}) - bias);
      end
   end

   always_comb begin
      for (int g = 0; g < q4bda_pkg::LANE_GROUPS; g++) begin
         entry.part[g] = '0;
         for (int k = 0; k < q4bda_pkg::GROUP_ELEMS; k++)
            entry.part[g] = entry.part[g]
               + q4bda_pkg::PART_W'($signed(prod[g*q4bda_pkg::GROUP_ELEMS + k]));
      end
      entry.d       = q4bda_pkg::half_decode(block_scale);
      entry.m       = q4bda_pkg::half_decode(block_offset);
      entry.act_sum = act_sum;
      entry.last    = last_block;
   end

endmodule

`default_nettype wire

@@ rtl/q4bda_queue.sv @@
// ----------------------------------------------------------------------------
// q4bda_queue
// short fifo of decoded blocks between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module q4bda_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire q4bda_pkg::entry_type push_entry,
   input  wire logic                 pop,
   output q4bda_pkg::entry_type      head,
   output logic                      full,
   output logic                      empty
);

   q4bda_pkg::entry_type mem [q4bda_pkg::QUEUE_DEPTH];
   logic [q4bda_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [q4bda_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == q4bda_pkg::QCNT_W'(q4bda_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + q4bda_pkg::QCNT_W'(push) - q4bda_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/q4bda_back.sv @@
// ----------------------------------------------------------------------------
// q4bda_back
// block term, saturating accumulate and final row scaling sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module q4bda_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        format_mode,
   input  wire logic [31:0] activation_scale,
   input  wire q4bda_pkg::entry_type head,
   input  wire logic        empty,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [63:0] rsp_row_result,
   output logic             rsp_overflowed
);

   q4bda_pkg::state_type state_ff, state_in;
   q4bda_pkg::entry_type entry_ff, entry_in;
   q4bda_pkg::cls_type   cls_ff, cls_in;
   logic signed [q4bda_pkg::DOT_W-1:0] dot_ff, dot_in;
   logic signed [29:0] dprod_ff, dprod_in;
   logic signed [24:0] mprod_ff, mprod_in;
   logic [63:0] acc_ff, acc_in;
   logic        sat_ff, sat_in;
   logic        neg_ff, neg_in;
   logic [31:0] maghi_ff, maghi_in;
   logic [63:0] lo_ff, lo_in, mid_ff, mid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_result_ff, rsp_result_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   logic        emit_ok;
   logic [63:0] dterm, mterm, term, mag;
   logic [64:0] acc_sum;
   logic [95:0] full_prod;
   logic [63:0] r;
   logic        r_ovf;

   assign emit_ok        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_result = rsp_result_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         q4bda_pkg::S_IDLE:   if (!empty) state_in = q4bda_pkg::S_TERM;
         q4bda_pkg::S_TERM:   state_in = q4bda_pkg::S_ACC;
         q4bda_pkg::S_ACC:    state_in = entry_ff.last ? q4bda_pkg::S_MUL_LO
                                                       : q4bda_pkg::S_IDLE;
         q4bda_pkg::S_MUL_LO: state_in = q4bda_pkg::S_MUL_HI;
         q4bda_pkg::S_MUL_HI: state_in = q4bda_pkg::S_ROUND;
         q4bda_pkg::S_ROUND:  if (emit_ok) state_in = q4bda_pkg::S_IDLE;
         default:             state_in = q4bda_pkg::S_IDLE;
      endcase
   end

   // datapath terms
   always_comb begin
      dterm = 64'($signed(dprod_ff)) <<< entry_ff.d.shift;
      if (entry_ff.d.neg) dterm = -dterm;
      mterm = 64'($signed(mprod_ff)) <<< entry_ff.m.shift;
      if (entry_ff.m.neg) mterm = -mterm;
      term    = format_mode ? dterm + mterm : dterm;
      acc_sum = {acc_ff[63], acc_ff} + {term[63], term};
      mag     = acc_ff[63] ? -acc_ff : acc_ff;
      full_prod = {32'd0, lo_ff} + {mid_ff, 32'd0} + q4bda_pkg::ROUND_HALF;
      r = full_prod[79:16];
      if (full_prod[95:80] != 16'd0) begin
         r_ovf = 1'b1;
         r     = neg_ff ? q4bda_pkg::ACC_MIN : q4bda_pkg::ACC_MAX;
      end else if (r[63] && (!neg_ff || r[62:0] != 63'd0)) begin
         r_ovf = 1'b1;
         r     = neg_ff ? q4bda_pkg::ACC_MIN : q4bda_pkg::ACC_MAX;
      end else begin
         r_ovf = 1'b0;
         r     = neg_ff ? -r : r;
      end
   end

   // outputs of each state
   always_comb begin
      pop           = 1'b0;
      entry_in      = entry_ff;
      dot_in        = dot_ff;
      dprod_in      = dprod_ff;
      mprod_in      = mprod_ff;
      cls_in        = cls_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      neg_in        = neg_ff;
      maghi_in      = maghi_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      case (state_ff)
         q4bda_pkg::S_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               entry_in = head;
               dot_in   = '0;
               for (int g = 0; g < q4bda_pkg::LANE_GROUPS; g++)
                  dot_in = dot_in + q4bda_pkg::DOT_W'($signed(head.part[g]));
            end
         end
         q4bda_pkg::S_TERM: begin
            dprod_in = $signed({1'b0, entry_ff.d.mant}) * dot_ff;
            mprod_in = $signed({1'b0, entry_ff.m.mant}) * entry_ff.act_sum;
            cls_in   = q4bda_pkg::half_cls(entry_ff.d, dot_ff == '0, dot_ff[q4bda_pkg::DOT_W-1]);
            if (format_mode)
               cls_in = q4bda_pkg::merge_cls(cls_in,
                           q4bda_pkg::half_cls(entry_ff.m, entry_ff.act_sum == '0,
                                               entry_ff.act_sum[12]));
         end
         q4bda_pkg::S_ACC: begin
            if (cls_ff != q4bda_pkg::CLS_FIN) begin
               acc_in = (cls_ff == q4bda_pkg::CLS_NINF) ? q4bda_pkg::ACC_MIN
                                                        : q4bda_pkg::ACC_MAX;
               sat_in = 1'b1;
            end else if (acc_sum[64] != acc_sum[63]) begin
               acc_in = acc_sum[64] ? q4bda_pkg::ACC_MIN : q4bda_pkg::ACC_MAX;
               sat_in = 1'b1;
            end else begin
               acc_in = acc_sum[63:0];
            end
         end
         q4bda_pkg::S_MUL_LO: begin
            neg_in   = acc_ff[63];
            maghi_in = mag[63:32];
            lo_in    = mag[31:0] * activation_scale;
         end
         q4bda_pkg::S_MUL_HI: begin
            mid_in = maghi_ff * activation_scale;
         end
         q4bda_pkg::S_ROUND: begin
            if (emit_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = r;
               rsp_ovf_in    = sat_ff || r_ovf;
               acc_in        = '0;
               sat_in        = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      dot_ff        <= dot_in;
      dprod_ff      <= dprod_in;
      mprod_ff      <= mprod_in;
      cls_ff        <= cls_in;
      neg_ff        <= neg_in;
      maghi_ff      <= maghi_in;
      lo_ff         <= lo_in;
      mid_ff        <= mid_in;
      rsp_result_ff <= rsp_result_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= q4bda_pkg::S_IDLE;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == q4bda_pkg::S_ROUND && emit_ok) |=> (acc_ff == '0 && !sat_ff))
      else $error("row state not cleared after result");

   a_rsp_from_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == q4bda_pkg::S_ROUND))
      else $error("result raised outside rounding step");

   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == q4bda_pkg::S_IDLE) else $error("pop while busy");

endmodule

`default_nettype wire

@@ rtl/q4_block_dot_accumulator_core.sv @@
// a row's last block goes through the queue, then the idle, term, acc, mul_lo, mul_hi and round
// steps of the back sequencer, which takes a new block from the queue only in its idle step
// the front takes an item every cycle while the 4-entry queue has room
// reset: synchronous, clears queue, sequencer, accumulator, saturation flag and result valid,
// format_mode to 0 and activation_scale to 1.0 (q16.16)
// ----------------------------------------------------------------------------
// q4_block_dot_accumulator_core
// q4_0 / q4_1 block quantised dot product with row accumulation and scaling
// ----------------------------------------------------------------------------
`default_nettype none

module q4_block_dot_accumulator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   // input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_nibbles_low,
   input  wire logic [63:0] req_nibbles_high,
   input  wire logic [63:0] req_act_word_0,
   input  wire logic [63:0] req_act_word_1,
   input  wire logic [63:0] req_act_word_2,
   input  wire logic [63:0] req_act_word_3,
   input  wire logic [15:0] req_block_scale,
   input  wire logic [15:0] req_block_offset,
   input  wire logic signed [12:0] req_act_sum,
   input  wire logic        req_last_block,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [63:0] rsp_row_result,
   output logic             rsp_overflowed
);

   logic        format_mode_ff, format_mode_in;
   logic [31:0] act_scale_ff, act_scale_in;

   q4bda_pkg::entry_type front_entry, queue_head;
   logic q_full, q_empty, q_pop, q_push;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      format_mode_in = format_mode_ff;
      act_scale_in   = act_scale_ff;
      if (csr_valid) begin
         case (csr_index)
            q4bda_pkg::CSR_FORMAT_MODE: format_mode_in = csr_wdata[0];
            q4bda_pkg::CSR_ACT_SCALE:   act_scale_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff <= 1'b0;
         act_scale_ff   <= q4bda_pkg::SCALE_RESET;
      end else begin
         format_mode_ff <= format_mode_in;
         act_scale_ff   <= act_scale_in;
      end
   end

   // front: lane products and fp16 decode, written straight into the queue
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   q4bda_front u_front (
      .format_mode  (format_mode_ff),
      .nibbles_low  (req_nibbles_low),
      .nibbles_high (req_nibbles_high),
      .act_word_0   (req_act_word_0),
      .act_word_1   (req_act_word_1),
      .act_word_2   (req_act_word_2),
      .act_word_3   (req_act_word_3),
      .block_scale  (req_block_scale),
      .block_offset (req_block_offset),
      .act_sum      (req_act_sum),
      .last_block   (req_last_block),
      .entry        (front_entry)
   );

   // decouples the item intake from the serial accumulate
   q4bda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (queue_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // back: block term, saturating accumulate, row scaling, result register
   q4bda_back u_back (
      .clock            (clock),
      .reset            (reset),
      .format_mode      (format_mode_ff),
      .activation_scale (act_scale_ff),
      .head             (queue_head),
      .empty            (q_empty),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_result   (rsp_row_result),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

`default_nettype wire

@@ tb/q4_block_dot_accumulator_core_tb.sv @@
// ----------------------------------------------------------------------------
// q4_block_dot_accumulator_core_tb
// drives weight blocks through the q4 dot accumulator and checks each row
// result against a bit-exact fixed-point model of the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module q4_block_dot_accumulator_core_tb;

   typedef struct {
      logic [63:0] nib_lo, nib_hi;
      logic [63:0] act [4];
      logic [15:0] d_bits, m_bits;
      logic signed [12:0] bsum;
      logic last;
   } block_type;

   typedef struct {
      logic signed [63:0] value;
      logic ovf;
   } row_type;

   // directed table row; has_exp marks rows whose row result is typed in
   typedef struct {
      block_type blk;
      logic has_exp;
      row_type exp_row;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0, csr_index = q4bda_pkg::CSR_FORMAT_MODE;
   logic [31:0] csr_wdata = '0;
   logic csr_ready;
   logic req_valid = 1'b0, req_ready;
   logic [63:0] req_nibbles_low = '0, req_nibbles_high = '0;
   logic [63:0] req_act_word_0 = '0, req_act_word_1 = '0;
   logic [63:0] req_act_word_2 = '0, req_act_word_3 = '0;
   logic [15:0] req_block_scale = '0, req_block_offset = '0;
   logic signed [12:0] req_act_sum = '0;
   logic req_last_block = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic signed [63:0] rsp_row_result;
   logic rsp_overflowed;

   // predictor copy of configuration and row state
   logic        fmt_q41;
   logic [31:0] act_scale;
   logic signed [63:0] row_acc;
   logic        row_sat;

   row_type pending_rows[$];
   int unsigned fail_count = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;

   always #10 clock = ~clock;

   q4_block_dot_accumulator_core uut (.*);

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   // fp16 times integer, exact in units of 2^-24
   function automatic q4bda_pkg::cls_type half_times(input logic [15:0] h, input int k,
                                                     output logic signed [63:0] t);
      logic [4:0] e;
      logic signed [63:0] mag;
      e = h[14:10];
      t = 0;
      if (e == 5'h1F) begin
         if (h[9:0] != 0 || k == 0) return q4bda_pkg::CLS_NAN;
         return (h[15] != (k < 0)) ? q4bda_pkg::CLS_NINF : q4bda_pkg::CLS_PINF;
      end
      mag = (e == 0) ? 64'(h[9:0]) : (64'({1'b1, h[9:0]}) << (e - 1));
      if (h[15]) mag = -mag;
      t = mag * 64'(signed'(k));
      return q4bda_pkg::CLS_FIN;
   endfunction

   function automatic q4bda_pkg::cls_type join_cls(input q4bda_pkg::cls_type a,
                                                   input q4bda_pkg::cls_type b);
      if (a == q4bda_pkg::CLS_FIN) return b;
      if (b == q4bda_pkg::CLS_FIN || a == b) return a;
      return q4bda_pkg::CLS_NAN;
   endfunction

   // round half away of acc * scale / 2^16, saturated
   function automatic row_type scale_row(input logic signed [63:0] a,
                                         input logic [31:0] s);
      logic [63:0] mag;
      logic [96:0] prod;
      row_type r;
      mag = a[63] ? -a : a;
      prod = ({33'd0, mag} * {65'd0, s}) + 97'h8000;
      prod = prod >> 16;
      r.ovf = 1'b0;
      if (!a[63]) begin
         if (prod > 97'h7FFF_FFFF_FFFF_FFFF) begin
            r.ovf = 1'b1; r.value = q4bda_pkg::ACC_MAX;
         end else r.value = prod[63:0];
      end else begin
         if (prod > 97'h8000_0000_0000_0000) begin
            r.ovf = 1'b1; r.value = q4bda_pkg::ACC_MIN;
         end else r.value = -prod[63:0];
      end
      return r;
   endfunction

   // advance the row model by one block; returns 1 with a row result on last
   function automatic logic predict_block(input block_type b, output row_type r);
      int bias, dot, wl, wh;
      logic [7:0] nb;
      logic signed [63:0] dt, mt;
      q4bda_pkg::cls_type c;
      bias = fmt_q41 ? 0 : q4bda_pkg::NIB_BIAS;
      dot = 0;
      for (int j = 0; j < 16; j++) begin
         nb = (j < 8) ? b.nib_lo[8*j +: 8] : b.nib_hi[8*(j-8) +: 8];
         wl = int'(nb[3:0]) - bias;
         wh = int'(nb[7:4]) - bias;
         dot += int'($signed(b.act[j/8][8*(j%8) +: 8])) * wl
              + int'($signed(b.act[2 + j/8][8*(j%8) +: 8])) * wh;
      end
      mt = 0;
      c = half_times(b.d_bits, dot, dt);
      if (fmt_q41) c = join_cls(c, half_times(b.m_bits, int'(b.bsum), mt));
      if (c == q4bda_pkg::CLS_FIN) begin
         if (dt + mt > 0 && row_acc > $signed(q4bda_pkg::ACC_MAX) - (dt + mt)) begin
            row_acc = q4bda_pkg::ACC_MAX; row_sat = 1'b1;
         end else if (dt + mt < 0 && row_acc < $signed(q4bda_pkg::ACC_MIN) - (dt + mt)) begin
            row_acc = q4bda_pkg::ACC_MIN; row_sat = 1'b1;
         end else row_acc += dt + mt;
      end else begin
         row_acc = (c == q4bda_pkg::CLS_NINF) ? q4bda_pkg::ACC_MIN : q4bda_pkg::ACC_MAX;
         row_sat = 1'b1;
      end
      if (!b.last) return 1'b0;
      r = scale_row(row_acc, act_scale);
      r.ovf |= row_sat;
      row_acc = 0;
      row_sat = 1'b0;
      return 1'b1;
   endfunction

   // one register write, then csr_valid is dropped again before the task returns
   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == q4bda_pkg::CSR_FORMAT_MODE) fmt_q41 = data[0];
      else act_scale = data;
      @(posedge clock);
   endtask

   // wait until every row result is in, plus the block latency
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // send one block; typed-in expectation overrides prediction where given
   task automatic send_block(input block_type b, input logic has_exp,
                             input row_type exp_row);
      row_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_nibbles_low <= b.nib_lo; req_nibbles_high <= b.nib_hi;
      req_act_word_0 <= b.act[0]; req_act_word_1 <= b.act[1];
      req_act_word_2 <= b.act[2]; req_act_word_3 <= b.act[3];
      req_block_scale <= b.d_bits; req_block_offset <= b.m_bits;
      req_act_sum <= b.bsum; req_last_block <= b.last;
      do @(posedge clock); while (!req_ready);
      if (predict_block(b, r)) pending_rows.push_back(has_exp ? exp_row : r);
   endtask

   function automatic logic [15:0] rand_half;
      case ($urandom_range(9))
         0: return {1'($urandom_range(1)), 5'h1F, 10'd0};
         1: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1, 1023))};
         2: return {1'($urandom_range(1)), 5'd0, 10'($urandom)};
         3: return {1'($urandom_range(1)), 5'($urandom_range(24, 30)), 10'($urandom)};
         default: return {1'($urandom_range(1)), 5'($urandom_range(5, 20)), 10'($urandom)};
      endcase
   endfunction

   function automatic block_type rand_block(input logic last);
      block_type b;
      int s;
      b.nib_lo = {$urandom, $urandom};
      b.nib_hi = {$urandom, $urandom};
      s = 0;
      for (int w = 0; w < 4; w++) begin
         if ($urandom_range(7) == 0) b.act[w] = {8{8'($urandom_range(1) ? 8'h80 : 8'h7F)}};
         else b.act[w] = {$urandom, $urandom};
         for (int i = 0; i < 8; i++) s += int'($signed(b.act[w][8*i +: 8]));
      end
      b.d_bits = rand_half();
      b.m_bits = rand_half();
      // mostly the true block sum, sometimes any 13-bit value
      b.bsum = ($urandom_range(3) == 0) ? 13'($urandom) : 13'(s);
      b.last = last;
      return b;
   endfunction

   function automatic block_type plain_block(input logic [63:0] nib, input logic [7:0] a,
                                             input logic [15:0] d, input logic [15:0] m,
                                             input logic signed [12:0] bs,
                                             input logic last);
      block_type b;
      b.nib_lo = nib; b.nib_hi = nib;
      for (int w = 0; w < 4; w++) b.act[w] = {8{a}};
      b.d_bits = d; b.m_bits = m; b.bsum = bs; b.last = last;
      return b;
   endfunction

   // result side: random stalls, compare with oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rows.size() == 0) begin
               report_mismatch("unexpected row_result", rsp_row_result, 64'd0);
            end else begin
               row_type w;
               w = pending_rows.pop_front();
               if (rsp_row_result !== w.value)
                  report_mismatch("row_result", rsp_row_result, w.value);
               if (rsp_overflowed !== w.ovf)
                  report_mismatch("overflowed", 64'(rsp_overflowed), 64'(w.ovf));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      table_row_type dir[$];
      row_type nr;
      block_type b;
      int len;
      fmt_q41 = 1'b0; act_scale = q4bda_pkg::SCALE_RESET; row_acc = 0; row_sat = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: q4_0 at reset settings
      nr.value = 0; nr.ovf = 0;
      // all nibbles 8 means zero weights
      dir.push_back('{plain_block({8{8'h88}}, 8'h7F, 16'h3C00, 0, 0, 1), 1, nr});
      // d = 1.0, weights -8, activations 1: dot = -256, times 2^24
      nr.value = -64'sd256 <<< 24;
      dir.push_back('{plain_block(0, 8'h01, 16'h3C00, 0, 0, 1), 1, nr});
      dir.push_back('{plain_block({8{8'hFF}}, 8'h80, 16'h7BFF, 16'hFFFF, -13'sd4096, 1),
                      0, nr});
      // infinity scale saturates high
      nr.value = q4bda_pkg::ACC_MAX; nr.ovf = 1;
      dir.push_back('{plain_block(0, 8'hFF, 16'h7C00, 0, 0, 1), 1, nr});
      // negative infinity times positive dot
      nr.value = q4bda_pkg::ACC_MIN;
      dir.push_back('{plain_block({8{8'hFF}}, 8'h01, 16'hFC00, 0, 0, 1), 1, nr});
      // infinity times zero dot is not a number
      nr.value = q4bda_pkg::ACC_MAX;
      dir.push_back('{plain_block({8{8'h88}}, 8'h01, 16'h7C00, 0, 0, 1), 1, nr});
      dir.push_back('{plain_block(0, 8'h01, 16'h7E01, 0, 0, 1), 1, nr});
      dir.push_back('{plain_block(0, 8'h80, 16'h0001, 0, 0, 0), 0, nr});
      dir.push_back('{plain_block({8{8'h5A}}, 8'h33, 16'h3555, 0, 0, 1), 0, nr});
      // accumulate towards overflow over several blocks
      for (int i = 0; i < 6; i++)
         dir.push_back('{plain_block(0, 8'h80, 16'h7BFF, 0, 0, i == 5), 0, nr});
      foreach (dir[i]) send_block(dir[i].blk, dir[i].has_exp, dir[i].exp_row);
      drain();

      // directed: q4_1 with offset term
      write_csr(q4bda_pkg::CSR_FORMAT_MODE, 32'd1);
      write_csr(q4bda_pkg::CSR_ACT_SCALE, 32'hFFFF_FFFF);
      dir.delete();
      dir.push_back('{plain_block({8{8'hFF}}, 8'h7F, 16'h3C00, 16'h3C00, 13'sd4064, 1),
                      0, nr});
      dir.push_back('{plain_block(0, 8'h80, 16'h0400, 16'hFBFF, -13'sd4096, 1), 0, nr});
      // opposite infinities in one block
      nr.value = q4bda_pkg::ACC_MAX; nr.ovf = 1;
      dir.push_back('{plain_block({8{8'h11}}, 8'h01, 16'h7C00, 16'hFC00, 13'sd32, 1), 1, nr});
      // offset infinity with zero block sum
      dir.push_back('{plain_block(0, 8'h01, 16'h3C00, 16'h7C00, 0, 1), 1, nr});
      dir.push_back('{plain_block({8{8'h12}}, 8'hF0, 16'h8001, 16'h0001, -13'sd1, 1), 0, nr});
      foreach (dir[i]) send_block(dir[i].blk, dir[i].has_exp, dir[i].exp_row);
      drain();

      // random phases over idling patterns and register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         write_csr(q4bda_pkg::CSR_FORMAT_MODE, 32'(ph & 1));
         case (ph)
            0: write_csr(q4bda_pkg::CSR_ACT_SCALE, 32'd0);
            5: write_csr(q4bda_pkg::CSR_ACT_SCALE, 32'hFFFF_FFFF);
            3, 6: write_csr(q4bda_pkg::CSR_ACT_SCALE, q4bda_pkg::SCALE_RESET);
            default: write_csr(q4bda_pkg::CSR_ACT_SCALE, $urandom);
         endcase
         for (int n = 0; n < 218;) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               b = rand_block(k == len - 1);
               send_block(b, 1'b0, nr);
            end
            n += len;
         end
         drain();
      end

      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
